[hw/rtl/lstat_pkg.sv]
package lstat_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int OP_W             = 2;
    localparam int CH_W             = 4;
    localparam int DATA_W           = 32;
    localparam int TOTAL_W          = 2 * DATA_W;
    localparam int Q_DEPTH          = 2;

    localparam logic [OP_W-1:0] OP_PRODUCE = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [DATA_W-1:0] MAX_DATA = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        K_PRODUCE,
        K_CONSUME,
        K_READ
    } t_kind;

    // classified event handed from the front end to the back end
    typedef struct packed {
        t_kind             kind;
        logic              in_range;
        logic [CH_W-1:0]   channel;
        logic [DATA_W-1:0] delay;
    } t_cmd;

    // one row of the statistics table
    typedef struct packed {
        logic [DATA_W-1:0]  made;
        logic [DATA_W-1:0]  eaten;
        logic [DATA_W-1:0]  min_d;
        logic [DATA_W-1:0]  max_d;
        logic [TOTAL_W-1:0] total;
    } t_entry;

    typedef struct packed {
        logic [DATA_W-1:0] made_count;
        logic [DATA_W-1:0] eaten_count;
        logic [DATA_W-1:0] min_delay;
        logic [DATA_W-1:0] max_delay;
        logic [DATA_W-1:0] avg_delay;
        logic              has_delay;
        logic              mismatch;
    } t_result;

endpackage

[hw/rtl/lstat_if.sv]
interface lstat_in_if;
    logic                          valid;
    logic                          ready;
    logic [lstat_pkg::OP_W-1:0]    operation;
    logic [lstat_pkg::CH_W-1:0]    channel;
    logic [lstat_pkg::DATA_W-1:0]  delay;

    modport source (output valid, output operation, output channel, output delay,
                    input ready);
    modport sink   (input valid, input operation, input channel, input delay,
                    output ready);
endinterface

interface lstat_out_if;
    logic                          valid;
    logic                          ready;
    logic [lstat_pkg::DATA_W-1:0]  made_count;
    logic [lstat_pkg::DATA_W-1:0]  eaten_count;
    logic [lstat_pkg::DATA_W-1:0]  min_delay;
    logic [lstat_pkg::DATA_W-1:0]  max_delay;
    logic [lstat_pkg::DATA_W-1:0]  avg_delay;
    logic                          has_delay;
    logic                          mismatch;

    modport source (output valid, output made_count, output eaten_count,
                    output min_delay, output max_delay, output avg_delay,
                    output has_delay, output mismatch, input ready);
    modport sink   (input valid, input made_count, input eaten_count,
                    input min_delay, input max_delay, input avg_delay,
                    input has_delay, input mismatch, output ready);
endinterface

[hw/rtl/lstat_front.sv]
module lstat_front #(
    parameter int NUM_CHANNELS = lstat_pkg::NUM_CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lstat_in_if.sink        i_in,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output lstat_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (lstat_pkg::Q_DEPTH > 1) ? $clog2(lstat_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(lstat_pkg::Q_DEPTH + 1);

    lstat_pkg::t_cmd  r_q [lstat_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    lstat_pkg::t_cmd  cmd_in;
    logic             push;
    logic             pop;

    // classify the incoming event
    always_comb begin
        cmd_in.channel  = i_in.channel;
        cmd_in.delay    = i_in.delay;
        cmd_in.in_range = (int'(i_in.channel) < NUM_CHANNELS);
        unique case (i_in.operation)
            lstat_pkg::OP_PRODUCE: cmd_in.kind = lstat_pkg::K_PRODUCE;
            lstat_pkg::OP_CONSUME: cmd_in.kind = lstat_pkg::K_CONSUME;
            default:               cmd_in.kind = lstat_pkg::K_READ;
        endcase
    end

    assign i_in.ready  = (r_cnt != CNT_W'(lstat_pkg::Q_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(lstat_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(lstat_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/lstat_div.sv]
module lstat_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lstat_pkg::TOTAL_W-1:0]  i_dividend,
    input  logic [lstat_pkg::DATA_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [lstat_pkg::DATA_W-1:0]   o_quotient
);

    localparam int DW    = lstat_pkg::DATA_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_sat;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_div;

    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             ge;

    // one quotient bit per cycle, remainder stays below the divisor
    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                if (r_sat || r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[lstat_pkg::TOTAL_W-1:DW];
            r_quo <= i_dividend[DW-1:0];
            r_div <= i_divisor;
            // quotient does not fit when the upper half already reaches the divisor
            r_sat <= (i_dividend[lstat_pkg::TOTAL_W-1:DW] >= i_divisor);
        end else if (r_busy && !r_sat) begin
            r_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sat ? lstat_pkg::MAX_DATA : r_quo;

endmodule

[hw/rtl/lstat_back.sv]
module lstat_back #(
    parameter int NUM_CHANNELS = lstat_pkg::NUM_CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  lstat_pkg::t_cmd i_cmd,
    lstat_out_if.source     o_out
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DW    = lstat_pkg::DATA_W;
    localparam int TW    = lstat_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                r_state;
    lstat_pkg::t_cmd       r_cmd;
    lstat_pkg::t_entry     r_ent;
    logic [DW-1:0]         r_avg;
    lstat_pkg::t_result    r_out;
    logic                  r_out_vld;

    lstat_pkg::t_entry     r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;
    lstat_pkg::t_entry     r_rd_data;
    logic                  r_rd_vld;

    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic                  wr_en;
    logic                  take;
    lstat_pkg::t_entry     old_ent;
    lstat_pkg::t_entry     n_ent;
    logic [TW:0]           sum;
    logic                  div_start;
    logic                  div_done;
    logic [DW-1:0]         div_quo;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign rd_idx      = IDX_W'(i_cmd.channel);
    assign wr_idx      = IDX_W'(r_cmd.channel);
    assign wr_en       = (r_state == S_UPD);

    // statistics table, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= n_ent;
        end
        r_rd_data <= r_mem[rd_idx];
        r_rd_vld  <= r_vld[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_idx] <= 1'b1;
        end
    end

    // read-modify-write of one row
    always_comb begin
        old_ent = r_rd_vld ? r_rd_data : '0;
        n_ent   = old_ent;
        sum     = {1'b0, old_ent.total} + (TW + 1)'(r_cmd.delay);
        unique case (r_cmd.kind)
            lstat_pkg::K_PRODUCE: begin
                if (old_ent.made != lstat_pkg::MAX_DATA) begin
                    n_ent.made = old_ent.made + 1'b1;
                end
            end
            lstat_pkg::K_CONSUME: begin
                if (old_ent.eaten == '0) begin
                    n_ent.min_d = r_cmd.delay;
                    n_ent.max_d = r_cmd.delay;
                    n_ent.total = TW'(r_cmd.delay);
                end else begin
                    if (r_cmd.delay < old_ent.min_d) begin
                        n_ent.min_d = r_cmd.delay;
                    end
                    if (r_cmd.delay > old_ent.max_d) begin
                        n_ent.max_d = r_cmd.delay;
                    end
                    n_ent.total = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
                end
                if (old_ent.eaten != lstat_pkg::MAX_DATA) begin
                    n_ent.eaten = old_ent.eaten + 1'b1;
                end
            end
            default: begin
                n_ent = old_ent;
            end
        endcase
    end

    assign div_start = (r_state == S_START) && (r_ent.eaten != '0);

    lstat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_ent.total),
        .i_divisor  (r_ent.eaten),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            // in S_OUT the load below decides the flag
            if (o_out.ready && r_state != S_OUT) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.in_range) begin
                            r_state <= S_UPD;
                        end else begin
                            r_ent   <= '0;
                            r_avg   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_UPD: begin
                    r_ent   <= n_ent;
                    r_state <= S_START;
                end
                S_START: begin
                    if (r_ent.eaten != '0) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_avg   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_avg   <= div_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || o_out.ready) begin
                        r_out.made_count  <= r_ent.made;
                        r_out.eaten_count <= r_ent.eaten;
                        r_out.has_delay   <= (r_ent.eaten != '0);
                        r_out.min_delay   <= (r_ent.eaten != '0) ? r_ent.min_d : '0;
                        r_out.max_delay   <= (r_ent.eaten != '0) ? r_ent.max_d : '0;
                        r_out.avg_delay   <= (r_ent.eaten != '0) ? r_avg : '0;
                        r_out.mismatch    <= (r_ent.made != r_ent.eaten);
                        r_out_vld         <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.made_count  = r_out.made_count;
    assign o_out.eaten_count = r_out.eaten_count;
    assign o_out.min_delay   = r_out.min_delay;
    assign o_out.max_delay   = r_out.max_delay;
    assign o_out.avg_delay   = r_out.avg_delay;
    assign o_out.has_delay   = r_out.has_delay;
    assign o_out.mismatch    = r_out.mismatch;

endmodule

[hw/rtl/per_channel_latency_stats_unit.sv]
// path from input transfer to result valid: queue, table read, update and the 32-step
// serial divider, which stops early when the average saturates and is skipped before any
// consume; out-of-range items skip both. The back end holds one item at a time, and a
// two-entry queue and the output register let both sides stall on their own
// reset: synchronous active-low i_rst_n clears control state and every table row valid bit,
// so all channels read as zero statistics straight after reset, no clearing pass
module per_channel_latency_stats_unit #(
    parameter int NUM_CHANNELS = lstat_pkg::NUM_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lstat_in_if.sink    i_in,
    lstat_out_if.source o_out
);

    // front end to back end command path
    logic            cmd_valid;
    logic            cmd_ready;
    lstat_pkg::t_cmd cmd;

    // front end: takes each input transfer, classifies the operation and
    // the channel range, and parks it in a short queue
    lstat_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // back end: read-modify-write of the channel row, serial average,
    // then the result register on the output channel
    lstat_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // back end works on one command at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("back end took a command while busy");

    // no delay recorded means the delay fields are all zero
    a_no_delay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_delay) |->
        (o_out.min_delay == '0 && o_out.max_delay == '0 && o_out.avg_delay == '0))
        else $error("delay fields set without a recorded delay");

    // minimum never above maximum, average never below minimum
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.has_delay) |->
        (o_out.min_delay <= o_out.max_delay && o_out.min_delay <= o_out.avg_delay))
        else $error("minimum delay out of order");
`endif

endmodule

[test/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH = lstat_pkg::NUM_CHANNELS_DEF;
    localparam int DW     = lstat_pkg::DATA_W;
    localparam int TW     = lstat_pkg::TOTAL_W;
    localparam int CHW    = lstat_pkg::CH_W;
    localparam int OPW    = lstat_pkg::OP_W;
    localparam int ITEMS = 1450;
    // the last stretch of items runs with both sides flat out
    localparam int TAIL_ITEMS = 200;
    // extra cycles after the last result
    localparam int DRAIN_CYCLES = 80;
    // long result-side hold-off, enough to fill the queue and stall the input
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 300;
    localparam logic [CHW-1:0] HOT_CH = 4'd9;
    // the fourth operation code has no name in the package and acts as a read
    localparam logic [OPW-1:0] OP_SPARE = 2'd3;

    // mirror of the statistics table plus the queue of results still to come
    class latency_scoreboard;
        logic [DW-1:0]        made_tab [NUM_CH];
        logic [DW-1:0]        eaten_tab [NUM_CH];
        logic [DW-1:0]        low_tab [NUM_CH];
        logic [DW-1:0]        high_tab [NUM_CH];
        logic [TW-1:0]        sum_tab [NUM_CH];
        lstat_pkg::t_result   pending_stats [$];
        int unsigned          fault_count;
        int unsigned          checked_count;
        int unsigned          op_seen [4];

        function new();
            foreach (made_tab[i]) begin
                made_tab[i]  = '0;
                eaten_tab[i] = '0;
                low_tab[i]   = '0;
                high_tab[i]  = '0;
                sum_tab[i]   = '0;
            end
            foreach (op_seen[i]) op_seen[i] = 0;
            fault_count   = 0;
            checked_count = 0;
        endfunction

        // apply one accepted event to the table copy and queue the statistics it returns
        function void fold_event(logic [OPW-1:0] op, logic [CHW-1:0] ch,
                                 logic [DW-1:0] d);
            lstat_pkg::t_result r;
            logic [TW-1:0]      quot;
            r = '0;
            op_seen[op]++;
            if (ch < NUM_CH) begin
                case (op)
                    lstat_pkg::OP_PRODUCE: begin
                        if (made_tab[ch] != lstat_pkg::MAX_DATA)
                            made_tab[ch] = made_tab[ch] + 1'b1;
                    end
                    lstat_pkg::OP_CONSUME: begin
                        if (eaten_tab[ch] == '0) begin
                            // first consume seeds minimum, maximum and total
                            low_tab[ch]  = d;
                            high_tab[ch] = d;
                            sum_tab[ch]  = {{DW{1'b0}}, d};
                        end else begin
                            if (d < low_tab[ch]) low_tab[ch] = d;
                            if (d > high_tab[ch]) high_tab[ch] = d;
                            // total sticks at all ones instead of wrapping
                            if ({{DW{1'b0}}, d} > ~sum_tab[ch]) sum_tab[ch] = '1;
                            else sum_tab[ch] = sum_tab[ch] + {{DW{1'b0}}, d};
                        end
                        if (eaten_tab[ch] != lstat_pkg::MAX_DATA)
                            eaten_tab[ch] = eaten_tab[ch] + 1'b1;
                    end
                    default: ;
                endcase
                if (eaten_tab[ch] != '0) begin
                    quot = sum_tab[ch] / {{DW{1'b0}}, eaten_tab[ch]};
                    r.min_delay = low_tab[ch];
                    r.max_delay = high_tab[ch];
                    r.avg_delay = (quot[TW-1:DW] != '0) ? lstat_pkg::MAX_DATA
                                                        : quot[DW-1:0];
                    r.has_delay = 1'b1;
                end
                r.made_count  = made_tab[ch];
                r.eaten_count = eaten_tab[ch];
                r.mismatch    = (made_tab[ch] != eaten_tab[ch]);
            end
            pending_stats.push_back(r);
        endfunction

        task report(string msg);
            fault_count++;
            $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, logic [DW-1:0] got, logic [DW-1:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %h expected %h",
                                 checked_count, name, got, want));
        endtask

        task check_result(lstat_pkg::t_result got);
            lstat_pkg::t_result want;
            if (pending_stats.size() == 0) begin
                report($sformatf("result with no event waiting, made %h eaten %h",
                                 got.made_count, got.eaten_count));
                return;
            end
            want = pending_stats.pop_front();
            compare_field("made_count", got.made_count, want.made_count);
            compare_field("eaten_count", got.eaten_count, want.eaten_count);
            compare_field("min_delay", got.min_delay, want.min_delay);
            compare_field("max_delay", got.max_delay, want.max_delay);
            compare_field("avg_delay", got.avg_delay, want.avg_delay);
            compare_field("has_delay", DW'(got.has_delay), DW'(want.has_delay));
            compare_field("mismatch", DW'(got.mismatch), DW'(want.mismatch));
            checked_count++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lstat_in_if  in_ch ();
    lstat_out_if out_ch ();

    per_channel_latency_stats_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    latency_scoreboard sb;
    int unsigned       items_sent = 0;
    int unsigned       stalled_cycles = 0;
    bit                quiet_tail = 1'b0;

    always #1 clk = ~clk;

    // delay values: half realistic (up to ~256 ms), with zero, all ones and full-range noise
    function automatic logic [DW-1:0] rand_delay();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick < 12) return $urandom_range(0, 32'h0003_ffff);
        return $urandom();
    endfunction

    // offer one event, optionally after an idle burst, and hold it until the transfer
    task automatic drive_item(logic [OPW-1:0] op, logic [CHW-1:0] ch,
                              logic [DW-1:0] d);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.channel   <= ch;
        in_ch.delay     <= d;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.fold_event(op, ch, d);
        items_sent++;
    endtask

    // result side: random stall bursts, one long hold-off, none in the tail
    initial begin : result_sink
        int stall_left;
        bit held;
        stall_left   = 0;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!held && sb.checked_count >= HOLD_AFTER) begin
                // keep the output blocked while the sender keeps offering events
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // sample both channels on the rising edge
    always @(posedge clk) begin : result_monitor
        lstat_pkg::t_result got;
        if (rst_n) begin
            if (in_ch.valid && !in_ch.ready) stalled_cycles++;
            if (out_ch.valid && out_ch.ready) begin
                got.made_count  = out_ch.made_count;
                got.eaten_count = out_ch.eaten_count;
                got.min_delay   = out_ch.min_delay;
                got.max_delay   = out_ch.max_delay;
                got.avg_delay   = out_ch.avg_delay;
                got.has_delay   = out_ch.has_delay;
                got.mismatch    = out_ch.mismatch;
                sb.check_result(got);
            end
        end
    end

    initial begin : stimulus
        logic [CHW-1:0] ch;
        logic [OPW-1:0] op;
        int unsigned    pick;

        sb = new();
        in_ch.valid     = 1'b0;
        in_ch.operation = lstat_pkg::OP_PRODUCE;
        in_ch.channel   = '0;
        in_ch.delay     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: untouched channels read as zero
        drive_item(lstat_pkg::OP_READ, 4'd0, '0);
        drive_item(OP_SPARE, 4'd15, '1);
        // produce before any consume: counts differ, no delay yet
        drive_item(lstat_pkg::OP_PRODUCE, 4'd0, '1);
        drive_item(lstat_pkg::OP_READ, 4'd0, '0);
        // first consume seeds the stats, then large delays push the total past 32 bits
        drive_item(lstat_pkg::OP_CONSUME, 4'd0, '0);
        drive_item(lstat_pkg::OP_CONSUME, 4'd0, '1);
        drive_item(lstat_pkg::OP_CONSUME, 4'd0, '1);
        drive_item(lstat_pkg::OP_CONSUME, 4'd0, '1);
        drive_item(OP_SPARE, 4'd0, '0);
        // top channel: maximum first, then the minimum drops
        drive_item(lstat_pkg::OP_CONSUME, 4'd15, '1);
        drive_item(lstat_pkg::OP_CONSUME, 4'd15, 32'd1);
        drive_item(lstat_pkg::OP_CONSUME, 4'd15, 32'h8000_0000);
        drive_item(lstat_pkg::OP_PRODUCE, 4'd15, '0);
        drive_item(lstat_pkg::OP_PRODUCE, 4'd15, '1);
        drive_item(lstat_pkg::OP_PRODUCE, 4'd15, 32'h5555_aaaa);
        drive_item(lstat_pkg::OP_READ, 4'd15, '1);
        // balanced counts clear the mismatch flag
        drive_item(lstat_pkg::OP_CONSUME, 4'd7, 32'h0000_0400);
        drive_item(lstat_pkg::OP_PRODUCE, 4'd7, '0);
        drive_item(lstat_pkg::OP_READ, 4'd7, '1);
        drive_item(lstat_pkg::OP_PRODUCE, 4'd8, '1);

        // random: mostly produce/consume pairs on one channel, the rest loose events
        while (items_sent < ITEMS) begin
            quiet_tail = (items_sent >= ITEMS - TAIL_ITEMS);
            if ($urandom_range(0, 3) == 0) ch = HOT_CH;
            else ch = CHW'($urandom_range(0, NUM_CH - 1));
            if ($urandom_range(0, 9) < 6) begin
                drive_item(lstat_pkg::OP_PRODUCE, ch, rand_delay());
                drive_item(lstat_pkg::OP_CONSUME, ch, rand_delay());
                if ($urandom_range(0, 3) == 0)
                    drive_item(lstat_pkg::OP_READ, ch, rand_delay());
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 3) op = lstat_pkg::OP_PRODUCE;
                else if (pick < 6) op = lstat_pkg::OP_CONSUME;
                else if (pick < 9) op = lstat_pkg::OP_READ;
                else op = OP_SPARE;
                drive_item(op, ch, rand_delay());
            end
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;

        while (sb.pending_stats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("drove %0d events: %0d produce, %0d consume, %0d read, %0d spare code",
                 items_sent, sb.op_seen[lstat_pkg::OP_PRODUCE],
                 sb.op_seen[lstat_pkg::OP_CONSUME], sb.op_seen[lstat_pkg::OP_READ],
                 sb.op_seen[OP_SPARE]);
        $display("checked %0d results, input back-pressured for %0d cycles",
                 sb.checked_count, stalled_cycles);
        if (sb.fault_count == 0 && sb.pending_stats.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // watchdog, several times the slowest expected run
    initial begin : watchdog
        #1_000_000;
        $display("run did not finish in time, %0d results outstanding",
                 sb.pending_stats.size());
        $display("testbench failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lstat_pkg.sv
hw/rtl/lstat_if.sv
hw/rtl/lstat_front.sv
hw/rtl/lstat_div.sv
hw/rtl/lstat_back.sv
hw/rtl/per_channel_latency_stats_unit.sv
test/testbench.sv
